/* rtl/ssg_pkg.sv */
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types, constants and the direction-number table of the Sobol
// sequence generator.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int MAX_DIMS   = 5;
  localparam int FRAC_W     = 30;
  localparam int DIM_W      = 3;
  localparam int CMD_W      = 2;
  localparam int BIT_W      = $clog2(FRAC_W);
  localparam int SKIP_STEPS = 64;
  localparam int SKIP_W     = $clog2(SKIP_STEPS);

  // command codes
  localparam logic [CMD_W-1:0] CMD_INIT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RANDOM = 2'd2;

  typedef logic [FRAC_W-1:0]            frac_t;
  typedef frac_t [FRAC_W-1:0]           dir_col_t;
  typedef dir_col_t [MAX_DIMS-1:0]      dir_tab_t;

  // primitive polynomials and their degrees
  localparam logic [7:0] POLY_CODE [MAX_DIMS] = '{8'd3, 8'd7, 8'd11, 8'd19, 8'd37};
  localparam int         POLY_DEG  [MAX_DIMS] = '{1, 2, 3, 4, 5};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_WALK,
    ST_EMIT,
    ST_ACK
  } ssg_state_t;

  // controller to datapath
  typedef struct packed {
    logic init_clr;
    logic adv;
    logic seed_load;
    logic gray_step;
    logic emit;
    logic ack;
  } ssg_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic seed_ovf;
    logic bit_last;
    logic emit_last;
    logic out_free;
  } ssg_stat_t;

  // Build direction numbers by the polynomial recurrence, initial values 1
  function automatic dir_tab_t build_dir_table();
    dir_tab_t    tab;
    logic [31:0] m [FRAC_W];
    logic [31:0] val;
    logic [7:0]  bits;
    int          d;
    tab = '0;
    for (int i = 0; i < MAX_DIMS; i++) begin
      d = POLY_DEG[i];
      for (int j = 0; j < FRAC_W; j++) begin
        if (j < d) begin
          val = 32'd1;
        end else begin
          bits = POLY_CODE[i];
          val  = m[j-d];
          for (int k = d; k > 0; k--) begin
            if (bits[0]) begin
              val = val ^ (m[j-k] << k);
            end
            bits = bits >> 1;
          end
        end
        m[j]      = val;
        tab[i][j] = FRAC_W'(val << (FRAC_W - 1 - j));
      end
    end
    return tab;
  endfunction

  localparam dir_tab_t DIR_TABLE = build_dir_table();

endpackage

/* rtl/ssg_ctrl.sv */
// ----------------------------------------------------------------------------
// ssg_ctrl
// Command sequencer: accepts commands, runs the init skip steps and the Gray
// code walk, and paces result transfers into the output register.
// ----------------------------------------------------------------------------
module ssg_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ssg_pkg::CMD_W-1:0] in_command,
  input  ssg_pkg::ssg_stat_t       stat,
  output ssg_pkg::ssg_cmd_t        cmd
);
  import ssg_pkg::*;

  ssg_state_t        state_r, state_nxt;
  logic [SKIP_W-1:0] skip_r, skip_nxt;

  // state and skip counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      skip_r  <= '0;
    end else begin
      state_r <= state_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    skip_nxt  = skip_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_command)
            CMD_INIT: begin
              cmd.init_clr = 1'b1;
              skip_nxt     = '0;
              state_nxt    = ST_SKIP;
            end
            CMD_NEXT: begin
              cmd.adv   = 1'b1;
              state_nxt = ST_EMIT;
            end
            CMD_RANDOM: begin
              cmd.seed_load = 1'b1;
              state_nxt     = stat.seed_ovf ? ST_EMIT : ST_WALK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SKIP: begin
        cmd.adv  = 1'b1;
        skip_nxt = skip_r + 1'b1;
        if (skip_r == SKIP_W'(SKIP_STEPS - 1)) begin
          state_nxt = ST_ACK;
        end
      end
      ST_WALK: begin
        cmd.gray_step = 1'b1;
        if (stat.bit_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ACK: begin
        if (stat.out_free) begin
          cmd.ack   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ssg_datapath.sv */
// ----------------------------------------------------------------------------
// ssg_datapath
// Point registers, sequence counter, Gray code walker, dimension count and
// the registered result stage.
// ----------------------------------------------------------------------------
module ssg_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ssg_pkg::FRAC_W-1:0] in_index,
  input  logic                      cfg_wr_en,
  input  logic [ssg_pkg::DIM_W-1:0] cfg_wr_data,
  input  ssg_pkg::ssg_cmd_t         cmd,
  output ssg_pkg::ssg_stat_t        stat,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ssg_pkg::DIM_W-1:0] out_dim_index,
  output logic [ssg_pkg::FRAC_W-1:0] out_coordinate,
  output logic                      out_last,
  output logic                      out_overflow
);
  import ssg_pkg::*;

  frac_t             point_r [MAX_DIMS];
  frac_t             cnt_r;
  frac_t             gray_r;
  logic [BIT_W-1:0]  bit_r;
  logic [DIM_W-1:0]  emit_idx_r;
  logic              ovf_r;
  logic [DIM_W-1:0]  dims_r;

  logic              out_valid_r;
  logic [DIM_W-1:0]  out_dim_r;
  frac_t             out_coord_r;
  logic              out_last_r;
  logic              out_ovf_r;

  frac_t             zero_pos;
  frac_t             step_dir [MAX_DIMS];
  logic              cnt_full;
  logic [FRAC_W:0]   seed;
  frac_t             seed_gray;
  logic [DIM_W-1:0]  n_act;
  logic              emit_last;
  logic              out_free;

  // pick the direction column at the lowest clear bit of the counter
  assign cnt_full = &cnt_r;
  assign zero_pos = ~cnt_r & (cnt_r + 1'b1);

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      step_dir[i] = '0;
      for (int j = 0; j < FRAC_W; j++) begin
        step_dir[i] = step_dir[i] | (DIR_TABLE[i][j] & {FRAC_W{zero_pos[j]}});
      end
    end
  end

  // seed for random access, offset by the skip steps plus one
  assign seed      = {1'b0, in_index} + (FRAC_W + 1)'(SKIP_STEPS + 1);
  assign seed_gray = seed[FRAC_W-1:0] ^ (seed[FRAC_W-1:0] >> 1);

  // clamp the dimension count
  always_comb begin
    if (dims_r == '0) begin
      n_act = DIM_W'(1);
    end else if (dims_r > DIM_W'(MAX_DIMS)) begin
      n_act = DIM_W'(MAX_DIMS);
    end else begin
      n_act = dims_r;
    end
  end

  assign emit_last = (emit_idx_r == n_act - 1'b1);
  assign out_free  = !out_valid_r || out_ready;

  assign stat.seed_ovf  = seed[FRAC_W];
  assign stat.bit_last  = (bit_r == BIT_W'(FRAC_W - 1));
  assign stat.emit_last = emit_last;
  assign stat.out_free  = out_free;

  // points, counter and walker
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        point_r[i] <= '0;
      end
      cnt_r      <= '0;
      gray_r     <= '0;
      bit_r      <= '0;
      emit_idx_r <= '0;
      ovf_r      <= 1'b0;
    end else begin
      if (cmd.init_clr) begin
        for (int i = 0; i < MAX_DIMS; i++) begin
          point_r[i] <= '0;
        end
        cnt_r      <= '0;
        emit_idx_r <= '0;
        ovf_r      <= 1'b0;
      end
      if (cmd.adv) begin
        emit_idx_r <= '0;
        ovf_r      <= cnt_full;
        if (!cnt_full) begin
          for (int i = 0; i < MAX_DIMS; i++) begin
            point_r[i] <= point_r[i] ^ step_dir[i];
          end
          cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.seed_load) begin
        emit_idx_r <= '0;
        ovf_r      <= seed[FRAC_W];
        gray_r     <= seed_gray;
        bit_r      <= '0;
        if (!seed[FRAC_W]) begin
          for (int i = 0; i < MAX_DIMS; i++) begin
            point_r[i] <= '0;
          end
        end
      end
      // fold in one Gray code bit per cycle
      if (cmd.gray_step) begin
        if (gray_r[0]) begin
          for (int i = 0; i < MAX_DIMS; i++) begin
            point_r[i] <= point_r[i] ^ DIR_TABLE[i][bit_r];
          end
        end
        gray_r <= gray_r >> 1;
        bit_r  <= bit_r + 1'b1;
      end
      if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
    end
  end

  // dimension count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIM_W'(MAX_DIMS);
    end else if (cfg_wr_en) begin
      dims_r <= cfg_wr_data;
    end
  end

  // result register: hold until transfer, load on emit or acknowledge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_dim_r   <= emit_idx_r;
      out_coord_r <= point_r[emit_idx_r];
      out_last_r  <= emit_last;
      out_ovf_r   <= ovf_r;
    end else if (cmd.ack) begin
      out_dim_r   <= '0;
      out_coord_r <= '0;
      out_last_r  <= 1'b1;
      out_ovf_r   <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dim_index  = out_dim_r;
  assign out_coordinate = out_coord_r;
  assign out_last       = out_last_r;
  assign out_overflow   = out_ovf_r;

endmodule

/* rtl/sobol_sequence_generator.sv */
// Next point: points advance at the accepting edge, then the coordinates load
// into the result register one per cycle while the output is not stalled.
// Random access: Gray code walk (one bit per cycle), then the emit.
// Init: 64 skip steps, one per cycle, then the acknowledgement.
// One command in flight; the next is taken once the last result is loaded.
// Synchronous active-low reset restores the points, counter and dims_in_use = 5.
// ----------------------------------------------------------------------------
// sobol_sequence_generator
// Sobol quasi-random point generator, Gray code scheme, up to five dimensions.
// ----------------------------------------------------------------------------
module sobol_sequence_generator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [ssg_pkg::CMD_W-1:0] in_command,
  input  logic [ssg_pkg::FRAC_W-1:0] in_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [ssg_pkg::DIM_W-1:0] out_dim_index,
  output logic [ssg_pkg::FRAC_W-1:0] out_coordinate,
  output logic                      out_last,
  output logic                      out_overflow,
  input  logic                      cfg_wr_en,
  input  logic [ssg_pkg::DIM_W-1:0] cfg_wr_data
);
  import ssg_pkg::*;

  ssg_cmd_t  cmd;
  ssg_stat_t stat;

  // sequencer
  ssg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd)
  );

  // point state and result stage
  ssg_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_index       (in_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dim_index  (out_dim_index),
    .out_coordinate (out_coordinate),
    .out_last       (out_last),
    .out_overflow   (out_overflow)
  );

endmodule
